[hw/rtl/odd_only_sieve_prime_count_unit_assert.svh]
// Assertion macros for the checker file of the prime count unit.
`ifndef ODD_ONLY_SIEVE_PRIME_COUNT_UNIT_ASSERT_SVH
`define ODD_ONLY_SIEVE_PRIME_COUNT_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define OSPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define OSPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/ospc_pkg.sv]
package ospc_pkg;

  // Field widths of the request and result channels
  localparam int LIMIT_W     = 17;
  localparam int COUNT_W     = 13;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;

  // Largest limit the sieve covers by default
  localparam int DEFAULT_MAX_LIMIT = 65536;

endpackage

[hw/rtl/odd_only_sieve_prime_count_unit.sv]
// Channel | Ports                             | Payload
// in      | in_tvalid, in_tready, in_tdata    | limit [16:0]
// out     | out_tvalid, out_tready, out_tdata | prime_count [12:0]
//
// One request at a time. Per request, the count sweep reads and clears S = (limit-1)/2
// entries; the sieve makes M mark writes (about 1.5*S at the default size) and walks
// K entries (a read and a wait each) to find the P sieving primes.
// All writes go through the single write port of the mark memory.
// After reset a clearing pass over all (MAX_LIMIT-1)/2 entries runs before the first request.
// The count waits in an output register; the next count stalls until out_tready takes it.
module odd_only_sieve_prime_count_unit #(
  parameter int MAX_LIMIT = ospc_pkg::DEFAULT_MAX_LIMIT
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [ospc_pkg::IN_TDATA_W-1:0]    in_tdata,   // [16:0] limit
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [ospc_pkg::OUT_TDATA_W-1:0]   out_tdata   // [12:0] prime_count
);
  import ospc_pkg::*;

  localparam int MARK_DEPTH = (MAX_LIMIT - 1) / 2;
  localparam int AW  = $clog2(MARK_DEPTH);
  localparam int IW  = $clog2(MARK_DEPTH + 1);
  localparam int NW  = $clog2(MAX_LIMIT + 1);
  localparam int EW  = (NW > LIMIT_W) ? NW : LIMIT_W;
  localparam int PW  = $clog2(2 * MARK_DEPTH + 4);
  localparam int PTW = $clog2(3 * MARK_DEPTH + 4);
  localparam int SW  = NW + 1;
  localparam int QW  = ((SW > PW + 3) ? SW : PW + 3) + 1;
  localparam logic [SW-1:0] SQ_SAT = {SW{1'b1}};

  typedef enum logic [7:0] {
    ST_CLEAR  = 8'b0000_0001,
    ST_IDLE   = 8'b0000_0010,
    ST_CHECK  = 8'b0000_0100,
    ST_MARK   = 8'b0000_1000,
    ST_STEP   = 8'b0001_0000,
    ST_WAIT   = 8'b0010_0000,
    ST_COUNT  = 8'b0100_0000,
    ST_RESULT = 8'b1000_0000
  } state_t;

  state_t               state_r, state_nxt;
  logic [NW-1:0]        n_r, n_nxt;
  logic [IW-1:0]        size_r, size_nxt;
  logic [IW-1:0]        scan_r, scan_nxt;
  logic [PW-1:0]        p_r, p_nxt;
  logic [SW-1:0]        psq_r, psq_nxt;
  logic [PTW-1:0]       ptr_r, ptr_nxt;
  logic [IW-1:0]        cnt_r, cnt_nxt;
  logic [COUNT_W-1:0]   tally_r, tally_nxt;
  logic                 pend_r, pend_nxt;
  logic                 out_tvalid_r, out_tvalid_nxt;
  logic [COUNT_W-1:0]   out_data_r, out_data_nxt;
  logic                 rd_bit_r;

  logic                 mem_we, mem_wdata, mem_re;
  logic [AW-1:0]        mem_waddr, mem_raddr;

  logic [EW-1:0]        lim_ext;
  logic [QW-1:0]        psq_sum;
  logic [IW-1:0]        scan_inc;

  logic                 mark_mem [MARK_DEPTH];

  // Mark memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mark_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_bit_r <= mark_mem[mem_raddr];
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_TDATA_W'(out_data_r);

  assign lim_ext  = EW'(in_tdata[LIMIT_W-1:0]);
  // Square of the next odd candidate: (p+2)^2 = p^2 + 4p + 4, saturated when stored in ST_STEP
  assign psq_sum  = QW'(psq_r) + (QW'(p_r) << 2) + QW'(4);
  assign scan_inc = IW'(scan_r + 1'b1);

  // Sequencer: clear, sieve, count, deliver
  always_comb begin
    state_nxt      = state_r;
    n_nxt          = n_r;
    size_nxt       = size_r;
    scan_nxt       = scan_r;
    p_nxt          = p_r;
    psq_nxt        = psq_r;
    ptr_nxt        = ptr_r;
    cnt_nxt        = cnt_r;
    tally_nxt      = tally_r;
    pend_nxt       = 1'b0;
    out_tvalid_nxt = out_tvalid_r;
    out_data_nxt   = out_data_r;
    mem_we         = 1'b0;
    mem_wdata      = 1'b0;
    mem_waddr      = cnt_r[AW-1:0];
    mem_re         = 1'b0;
    mem_raddr      = cnt_r[AW-1:0];

    // Drop the result once the consumer takes it
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    // Tally an unmarked entry read by the count sweep
    if (pend_r && !rd_bit_r) begin
      tally_nxt = COUNT_W'(tally_r + 1'b1);
    end

    case (state_r)
      ST_CLEAR: begin
        mem_we  = 1'b1;
        cnt_nxt = IW'(cnt_r + 1'b1);
        if (cnt_r == IW'(MARK_DEPTH - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          if (lim_ext > EW'(MAX_LIMIT)) begin
            n_nxt = NW'(MAX_LIMIT);
          end else begin
            n_nxt = NW'(lim_ext);
          end
          if (n_nxt >= NW'(3)) begin
            size_nxt = IW'((n_nxt - 1'b1) >> 1);
          end else begin
            size_nxt = '0;
          end
          tally_nxt = (n_nxt >= NW'(2)) ? COUNT_W'(1) : '0;
          scan_nxt  = '0;
          p_nxt     = PW'(3);
          psq_nxt   = SW'(9);
          cnt_nxt   = '0;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (psq_r <= SW'(n_r) && scan_r < size_r) begin
          ptr_nxt   = PTW'(scan_r) + PTW'(p_r);
          state_nxt = ST_MARK;
        end else begin
          cnt_nxt   = '0;
          state_nxt = ST_COUNT;
        end
      end
      ST_MARK: begin
        if (ptr_r < PTW'(size_r)) begin
          mem_we    = 1'b1;
          mem_wdata = 1'b1;
          mem_waddr = ptr_r[AW-1:0];
          ptr_nxt   = PTW'(ptr_r + PTW'(p_r));
        end else begin
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        // Advance to the next odd candidate and fetch its mark while it is inside the sieve
        scan_nxt = scan_inc;
        p_nxt    = PW'(p_r + PW'(2));
        psq_nxt  = (psq_sum > QW'(SQ_SAT)) ? SQ_SAT : SW'(psq_sum);
        if (scan_inc >= size_r) begin
          state_nxt = ST_CHECK;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = scan_inc[AW-1:0];
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        state_nxt = rd_bit_r ? ST_STEP : ST_CHECK;
      end
      ST_COUNT: begin
        // Read each entry and clear it behind the read
        if (cnt_r < size_r) begin
          mem_re    = 1'b1;
          mem_we    = 1'b1;
          mem_wdata = 1'b0;
          pend_nxt  = 1'b1;
          cnt_nxt   = IW'(cnt_r + 1'b1);
        end else begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_data_nxt   = tally_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      cnt_r        <= '0;
      pend_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      pend_r       <= pend_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Working values and payload
  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    size_r     <= size_nxt;
    scan_r     <= scan_nxt;
    p_r        <= p_nxt;
    psq_r      <= psq_nxt;
    ptr_r      <= ptr_nxt;
    tally_r    <= tally_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

[hw/rtl/ospc_checker.sv]
`include "odd_only_sieve_prime_count_unit_assert.svh"

module ospc_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  input  logic                               in_tready,
  input  logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic [ospc_pkg::OUT_TDATA_W-1:0]   out_tdata   // [12:0] prime_count
);
  import ospc_pkg::*;

  // Hold a stalled result
  `OSPC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata), "result changed while stalled")

  // Keep the padding of the result clear
  `OSPC_ASSERT_NOW(a_out_pad, out_tvalid,
    out_tdata[OUT_TDATA_W-1:COUNT_W] == '0, "result padding not zero")

  // Drop ready once a request is taken
  `OSPC_ASSERT_NEXT(a_busy_after_req, in_tvalid && in_tready,
    !in_tready, "second request taken while busy")

  // Raise a result only out of a busy period
  `OSPC_ASSERT_NOW(a_result_from_busy, $rose(out_tvalid),
    $past(!in_tready), "result without a request in progress")

endmodule

bind odd_only_sieve_prime_count_unit ospc_checker u_ospc_checker (.*);

[test/tb_odd_only_sieve_prime_count_unit.sv]
module tb_odd_only_sieve_prime_count_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import ospc_pkg::*;

  localparam int MARK_DEPTH   = (DEFAULT_MAX_LIMIT - 1) / 2;
  localparam int RANDOM_REQS  = 75;
  localparam int HOLD_AT      = 20;
  localparam int HOLD_CYCLES  = 8000;
  localparam int DRAIN_CYCLES = 2000;
  localparam int CALM_FIRST   = 40;
  localparam int CALM_LAST    = 70;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  logic [LIMIT_W-1:0] limits_to_send [$];
  logic [COUNT_W-1:0] pending_counts [$];
  logic [LIMIT_W-1:0] next_limit;
  logic [COUNT_W-1:0] want_count;
  bit                 odd_marks [MARK_DEPTH];
  bit                 in_taken = 1'b0;
  int                 n_requests = 0;
  int                 req_sent = 0;
  int                 res_seen = 0;
  int                 mismatch_cnt = 0;
  int                 hold_left = 0;
  bit                 hold_done = 1'b0;

  odd_only_sieve_prime_count_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Count primes up to the limit with an odd-only sieve; index i is 2i+3
  function automatic logic [COUNT_W-1:0] sieve_count(input logic [LIMIT_W-1:0] lim);
    longint unsigned n;
    longint unsigned span;
    longint unsigned idx;
    longint unsigned prime;
    longint unsigned ptr;
    longint unsigned tally;
    n = lim;
    if (n > DEFAULT_MAX_LIMIT) n = DEFAULT_MAX_LIMIT;
    if (n < 2) return '0;
    span = (n >= 3) ? (n - 3) / 2 + 1 : 0;
    if (span > MARK_DEPTH) span = MARK_DEPTH;
    foreach (odd_marks[i]) odd_marks[i] = 1'b0;
    idx = 0;
    prime = 3;
    while (prime * prime <= n && idx < span) begin
      // strike 3p, 5p, 7p, ... inside the sieve
      for (ptr = 3 * idx + 3; ptr < span; ptr += prime) odd_marks[ptr] = 1'b1;
      // step to the next unmarked entry, stopping at the end of the sieve
      idx++;
      while (idx < span && odd_marks[idx]) idx++;
      prime = 2 * idx + 3;
    end
    // one extra for the prime 2
    tally = 1;
    for (ptr = 0; ptr < span; ptr++) if (!odd_marks[ptr]) tally++;
    return tally[COUNT_W-1:0];
  endfunction

  task automatic flag_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $realtime, what);
    mismatch_cnt++;
  endtask

  // Sample both channels; predict on each accepted request, check each count
  always @(posedge clk) begin
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        pending_counts.push_back(sieve_count(in_tdata[LIMIT_W-1:0]));
        req_sent++;
      end
      if (out_tvalid && out_tready) begin
        if (pending_counts.size() == 0) begin
          flag_mismatch($sformatf("count %0d with no request waiting",
                                  out_tdata[COUNT_W-1:0]));
        end else begin
          want_count = pending_counts.pop_front();
          if (out_tdata[COUNT_W-1:0] !== want_count)
            flag_mismatch($sformatf("result %0d: prime_count %0d, expected %0d",
                                    res_seen, out_tdata[COUNT_W-1:0], want_count));
        end
        res_seen++;
      end
    end
  end

  // Drive requests from the pending list; hold each one until it is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else if (!in_tvalid || in_taken) begin
      if (limits_to_send.size() != 0 &&
          ((req_sent >= CALM_FIRST && req_sent < CALM_LAST) ||
           $urandom_range(99) >= 15)) begin
        next_limit = limits_to_send.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {{(IN_TDATA_W-LIMIT_W){1'b0}}, next_limit};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off once, so the block fills up and stalls its input
  always @(negedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && res_seen == HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Random receiver stalls, none inside the calm stretch
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= (hold_left == 0) &&
                    ((res_seen >= CALM_FIRST && res_seen < CALM_LAST) ||
                     $urandom_range(99) >= 15);
    end
  end

  initial begin
    int pick;
    // small limits, squares of primes, neighbors of powers of two, and
    // limits at and past the top, which saturate
    limits_to_send = '{17'd0, 17'd1, 17'd2, 17'd3, 17'd4, 17'd5, 17'd7, 17'd8,
                       17'd9, 17'd10, 17'd24, 17'd25, 17'd26, 17'd48, 17'd49,
                       17'd120, 17'd121, 17'd169, 17'd1023, 17'd1024,
                       17'd65535, 17'd65536, 17'd65537, 17'd131071, 17'd6};
    // mostly small limits, some medium, a few large ones
    repeat (RANDOM_REQS) begin
      pick = $urandom_range(99);
      if (pick < 85)
        limits_to_send.push_back(LIMIT_W'($urandom_range(511)));
      else if (pick < 97)
        limits_to_send.push_back(LIMIT_W'($urandom_range(8191, 512)));
      else
        limits_to_send.push_back(LIMIT_W'($urandom_range(131071, 8192)));
    end
    n_requests = limits_to_send.size();

    repeat (4) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // wait out all requests and their counts, then a quiet spell
    while (req_sent < n_requests || pending_counts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/ospc_pkg.sv
hw/rtl/odd_only_sieve_prime_count_unit.sv
hw/rtl/ospc_checker.sv
test/tb_odd_only_sieve_prime_count_unit.sv
